// File: hdl/mrs_pkg.sv
// Shared types, codes and the CRC-16 byte step for the Modbus RTU register slave.
// Used by mrs_front, mrs_back, the top level and mrs_checker; depends on nothing.
package mrs_pkg;

    // input actions
    localparam logic [2:0] ACT_RX_BYTE   = 3'd0;
    localparam logic [2:0] ACT_LINE_ERR  = 3'd1;
    localparam logic [2:0] ACT_HOLD_WR   = 3'd2;
    localparam logic [2:0] ACT_INPUT_WR  = 3'd3;
    localparam logic [2:0] ACT_HOLD_RD   = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_TX       = 2'd0;
    localparam logic [1:0] KIND_READ     = 2'd1;
    localparam logic [1:0] KIND_CRC_ERR  = 2'd2;

    // function codes
    localparam logic [7:0] FC_RD_HOLD    = 8'd3;
    localparam logic [7:0] FC_RD_INPUT   = 8'd4;
    localparam logic [7:0] FC_WR_SINGLE  = 8'd6;
    localparam logic [7:0] FC_WR_MULTI   = 8'd16;

    // exception response
    localparam logic [7:0] EXC_FLAG         = 8'h80;
    localparam logic [7:0] EXC_ILLEGAL_FUNC = 8'h01;
    localparam logic [7:0] EXC_ILLEGAL_ADDR = 8'h02;

    // frame lengths
    localparam logic [9:0] FRAME_MIN_LEN   = 10'd6;
    localparam logic [9:0] FRAME_FIXED_LEN = 10'd8;
    localparam logic [9:0] FRAME_BC_LEN    = 10'd7;
    localparam logic [9:0] FRAME_MULTI_OVH = 10'd9;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // configuration register indexes
    localparam logic [2:0] CFG_SLAVE_ADDR = 3'd0;
    localparam logic [2:0] CFG_RESET_CMD  = 3'd1;
    localparam logic [2:0] CFG_FIRST_ERR  = 3'd2;
    localparam logic [2:0] CFG_SECOND_ERR = 3'd3;
    localparam logic [2:0] CFG_SYSTEM_ERR = 3'd4;

    typedef struct packed {
        logic [7:0] slave_address;
        logic [5:0] reset_cmd_idx;
        logic [5:0] first_err_idx;
        logic [5:0] second_err_idx;
        logic [5:0] system_err_idx;
    } t_cfg;

    typedef enum logic [1:0] {
        CMD_HOLD_WR,
        CMD_INPUT_WR,
        CMD_HOLD_RD,
        CMD_FRAME
    } t_cmd_op;

    // one request from the front end to the engine
    typedef struct packed {
        t_cmd_op     op;
        logic [5:0]  index;
        logic [15:0] value;
        logic        crc_ok;
        logic [7:0]  fc;
        logic [15:0] start;
        logic [15:0] qty;
        logic [7:0]  byte_count;
    } t_cmd;

    typedef struct packed {
        logic        en;
        logic [7:0]  addr;
        logic [7:0]  data;
    } t_fbuf_wr;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic [15:0] read_value;
    } t_result;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_HOLD_WR,
        ST_INPUT_WR,
        ST_HOLD_RD,
        ST_LOCAL_OUT,
        ST_CHECK,
        ST_CRC_ERR,
        ST_W6,
        ST_CLR1,
        ST_CLR2,
        ST_CLR3,
        ST_W16_RH,
        ST_W16_RL,
        ST_W16_WR,
        ST_HDR,
        ST_RD_ISSUE,
        ST_RD_HI,
        ST_RD_LO,
        ST_CRC_LO,
        ST_CRC_HI
    } t_back_state;

    // fold one byte into a reflected CRC-16
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// File: hdl/mrs_fifo.sv
// Small synchronous queue of flat words.
// Depends on nothing; used for the request queue and the result queue.
module mrs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, r_rptr;
    logic [AW:0]      r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            if (do_pop)  r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

    // hold entries
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wptr] <= i_data;
    end
endmodule

// File: hdl/mrs_front.sv
// Front end: takes input items, assembles frames, checks address and CRC.
// Depends on mrs_pkg; feeds requests to the engine and bytes to its frame buffer.
module mrs_front #(
    parameter int FRAME_BUFFER_BYTES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [2:0]        i_action,
    input  logic [7:0]        i_rx_byte,
    input  logic [5:0]        i_local_index,
    input  logic [15:0]       i_local_value,
    input  mrs_pkg::t_cfg     i_cfg,
    output logic              o_cmd_push,
    output mrs_pkg::t_cmd     o_cmd,
    input  logic              i_cmd_full,
    output mrs_pkg::t_fbuf_wr o_fbuf_wr,
    input  logic              i_frame_done
);
    import mrs_pkg::*;

    localparam int FW = $clog2(FRAME_BUFFER_BYTES);

    logic [FW-1:0] r_count, n_count;
    logic          r_pend, n_pend;
    logic [15:0]   r_crc_cur, n_crc_cur, r_crc_prev, n_crc_prev;
    logic [7:0]    r_last, n_last;
    logic [7:0]    r_hdr [0:6];
    logic [7:0]    hdr_now [0:6];
    logic [FW:0]   c1;
    logic [9:0]    c1_w, need_multi;
    logic          accept, is_byte, overflow, complete, fixed_len, crc_ok, addr_ok;

    assign o_full   = i_cmd_full | r_pend;
    assign accept   = i_push & ~o_full;
    assign is_byte  = accept && (i_action == ACT_RX_BYTE);
    assign overflow = (r_count >= FW'(FRAME_BUFFER_BYTES - 1));
    assign c1       = {1'b0, r_count} + 1'b1;
    assign c1_w     = 10'(c1);

    // header view including the byte now arriving
    always_comb begin
        for (int k = 0; k < 7; k++) begin
            hdr_now[k] = (r_count == FW'(k)) ? i_rx_byte : r_hdr[k];
        end
    end

    assign fixed_len  = (hdr_now[1] == FC_RD_HOLD) || (hdr_now[1] == FC_RD_INPUT) ||
                        (hdr_now[1] == FC_WR_SINGLE);
    assign need_multi = FRAME_MULTI_OVH + 10'(hdr_now[6]);

    // decide whether this byte closes the frame
    always_comb begin
        if (c1_w < FRAME_MIN_LEN) begin
            complete = 1'b0;
        end else if (fixed_len) begin
            complete = (c1_w >= FRAME_FIXED_LEN);
        end else if (hdr_now[1] == FC_WR_MULTI) begin
            complete = (c1_w >= FRAME_BC_LEN) && (c1_w >= need_multi);
        end else begin
            complete = 1'b1;
        end
    end

    assign crc_ok  = (r_last == r_crc_prev[7:0]) && (i_rx_byte == r_crc_prev[15:8]);
    assign addr_ok = (hdr_now[0] == i_cfg.slave_address);

    // collect bytes and issue requests
    always_comb begin
        n_count    = r_count;
        n_pend     = r_pend;
        n_crc_cur  = r_crc_cur;
        n_crc_prev = r_crc_prev;
        n_last     = r_last;
        o_cmd_push = 1'b0;
        o_fbuf_wr  = '0;
        o_cmd      = '0;
        o_cmd.index      = i_local_index;
        o_cmd.value      = i_local_value;
        o_cmd.crc_ok     = crc_ok;
        o_cmd.fc         = hdr_now[1];
        o_cmd.start      = {hdr_now[2], hdr_now[3]};
        o_cmd.qty        = {hdr_now[4], hdr_now[5]};
        o_cmd.byte_count = hdr_now[6];
        if (i_frame_done) n_pend = 1'b0;
        if (accept) begin
            case (i_action)
                ACT_RX_BYTE: begin
                    if (overflow) begin
                        n_count   = '0;
                        n_crc_cur = CRC_INIT;
                    end else begin
                        o_fbuf_wr.en   = 1'b1;
                        o_fbuf_wr.addr = 8'(r_count);
                        o_fbuf_wr.data = i_rx_byte;
                        n_crc_prev     = r_crc_cur;
                        n_crc_cur      = crc_byte(r_crc_cur, i_rx_byte);
                        n_last         = i_rx_byte;
                        n_count        = c1[FW-1:0];
                        if (complete) begin
                            n_count   = '0;
                            n_crc_cur = CRC_INIT;
                            if (addr_ok) begin
                                o_cmd.op   = CMD_FRAME;
                                o_cmd_push = 1'b1;
                                n_pend     = 1'b1;
                            end
                        end
                    end
                end
                ACT_LINE_ERR: begin
                    n_count   = '0;
                    n_crc_cur = CRC_INIT;
                end
                ACT_HOLD_WR: begin
                    o_cmd.op   = CMD_HOLD_WR;
                    o_cmd_push = 1'b1;
                end
                ACT_INPUT_WR: begin
                    o_cmd.op   = CMD_INPUT_WR;
                    o_cmd_push = 1'b1;
                end
                ACT_HOLD_RD: begin
                    o_cmd.op   = CMD_HOLD_RD;
                    o_cmd_push = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_pend     <= 1'b0;
            r_crc_cur  <= CRC_INIT;
            r_crc_prev <= CRC_INIT;
            r_last     <= '0;
        end else begin
            r_count    <= n_count;
            r_pend     <= n_pend;
            r_crc_cur  <= n_crc_cur;
            r_crc_prev <= n_crc_prev;
            r_last     <= n_last;
        end
    end

    // hold header bytes
    always_ff @(posedge i_clk) begin
        if (is_byte && !overflow) begin
            for (int k = 0; k < 7; k++) r_hdr[k] <= hdr_now[k];
        end
    end
endmodule

// File: hdl/mrs_back.sv
// Engine: carries out requests, owns the register files and frame buffer,
// builds responses. Depends on mrs_pkg.
module mrs_back #(
    parameter int HOLDING_COUNT      = 64,
    parameter int INPUT_COUNT        = 16,
    parameter int FRAME_BUFFER_BYTES = 64,
    parameter int MAX_READ_QTY       = 29
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mrs_pkg::t_cfg     i_cfg,
    input  logic              i_cmd_empty,
    output logic              o_cmd_pop,
    input  mrs_pkg::t_cmd     i_cmd,
    input  mrs_pkg::t_fbuf_wr i_fbuf_wr,
    output logic              o_res_push,
    output mrs_pkg::t_result  o_res,
    input  logic              i_res_full,
    output logic              o_frame_done
);
    import mrs_pkg::*;

    localparam int HW   = (HOLDING_COUNT > 1) ? $clog2(HOLDING_COUNT) : 1;
    localparam int IW   = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;
    localparam int FW   = $clog2(FRAME_BUFFER_BYTES);
    localparam int MAXC = (HOLDING_COUNT > INPUT_COUNT) ? HOLDING_COUNT : INPUT_COUNT;
    localparam int PW   = $clog2(MAXC + 1);
    localparam logic [16:0] HC17  = 17'(HOLDING_COUNT);
    localparam logic [16:0] IC17  = 17'(INPUT_COUNT);
    localparam logic [16:0] MRQ17 = 17'(MAX_READ_QTY);

    t_back_state r_state, n_state;
    t_cmd        r_cmd, n_cmd;
    logic [7:0]  r_txh [0:5];
    logic [7:0]  n_txh [0:5];
    logic [2:0]  r_hlen, n_hlen, r_hidx, n_hidx;
    logic        r_isread, n_isread;
    logic [PW-1:0] r_ptr, n_ptr;
    logic [7:0]  r_left, n_left;
    logic [FW:0] r_fptr, n_fptr;
    logic [7:0]  r_hi, n_hi;
    logic [15:0] r_tcrc, n_tcrc;

    // register files and frame buffer
    logic [15:0]            m_hold [HOLDING_COUNT];
    logic [HOLDING_COUNT-1:0] r_hvld;
    logic [15:0]            m_in [INPUT_COUNT];
    logic [INPUT_COUNT-1:0] r_ivld;
    logic [7:0]             m_frame [FRAME_BUFFER_BYTES];
    logic [15:0]            r_hq, r_iq;
    logic [7:0]             r_frd;

    logic          h_we, h_re, in_we, in_re, f_re;
    logic [HW-1:0] h_waddr, h_raddr;
    logic [15:0]   h_wdata;
    logic [IW-1:0] in_waddr, in_raddr;
    logic [FW-1:0] f_raddr;

    logic [16:0] span, start17;
    logic        fc_rd, rd_ok, w6_ok, w16_ok, rst_hit, last_hdr, res_ok;
    logic [15:0] rd_word;
    logic [7:0]  hdr_byte;

    // judge the request in hand
    assign start17  = 17'(r_cmd.start);
    assign span     = start17 + 17'(r_cmd.qty);
    assign fc_rd    = (r_cmd.fc == FC_RD_HOLD) || (r_cmd.fc == FC_RD_INPUT);
    assign rd_ok    = (span <= ((r_cmd.fc == FC_RD_HOLD) ? HC17 : IC17)) &&
                      (17'(r_cmd.qty) <= MRQ17);
    assign w6_ok    = (start17 < HC17);
    assign w16_ok   = (span <= HC17) && (17'(r_cmd.byte_count) == {r_cmd.qty, 1'b0});
    assign rst_hit  = (r_cmd.start == 16'(i_cfg.reset_cmd_idx)) && (r_cmd.qty == 16'd1);
    assign last_hdr = (r_hidx == r_hlen - 3'd1);
    assign res_ok   = ~i_res_full;
    assign rd_word  = (r_cmd.fc == FC_RD_HOLD) ? r_hq : r_iq;
    assign hdr_byte = r_txh[r_hidx];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_cmd_empty) begin
                    case (i_cmd.op)
                        CMD_HOLD_WR:  n_state = ST_HOLD_WR;
                        CMD_INPUT_WR: n_state = ST_INPUT_WR;
                        CMD_HOLD_RD:  n_state = ST_HOLD_RD;
                        CMD_FRAME:    n_state = ST_CHECK;
                        default:      n_state = ST_IDLE;
                    endcase
                end
            end
            ST_HOLD_WR:   n_state = ST_IDLE;
            ST_INPUT_WR:  n_state = ST_IDLE;
            ST_HOLD_RD:   n_state = ST_LOCAL_OUT;
            ST_LOCAL_OUT: if (res_ok) n_state = ST_IDLE;
            ST_CHECK: begin
                if (!r_cmd.crc_ok) begin
                    n_state = ST_CRC_ERR;
                end else if (r_cmd.fc == FC_WR_SINGLE) begin
                    n_state = w6_ok ? ST_W6 : ST_HDR;
                end else if (r_cmd.fc == FC_WR_MULTI) begin
                    n_state = (w16_ok && (r_cmd.qty != 16'd0)) ? ST_W16_RH : ST_HDR;
                end else begin
                    n_state = ST_HDR;
                end
            end
            ST_CRC_ERR:   if (res_ok) n_state = ST_IDLE;
            ST_W6:        n_state = rst_hit ? ST_CLR1 : ST_HDR;
            ST_CLR1:      n_state = ST_CLR2;
            ST_CLR2:      n_state = ST_CLR3;
            ST_CLR3:      n_state = ST_HDR;
            ST_W16_RH:    n_state = ST_W16_RL;
            ST_W16_RL:    n_state = ST_W16_WR;
            ST_W16_WR:    n_state = (r_left == 8'd1) ? ST_HDR : ST_W16_RH;
            ST_HDR: begin
                if (res_ok && last_hdr) begin
                    n_state = (r_isread && (r_left != 8'd0)) ? ST_RD_ISSUE : ST_CRC_LO;
                end
            end
            ST_RD_ISSUE:  n_state = ST_RD_HI;
            ST_RD_HI:     if (res_ok) n_state = ST_RD_LO;
            ST_RD_LO: begin
                if (res_ok) n_state = (r_left == 8'd1) ? ST_CRC_LO : ST_RD_ISSUE;
            end
            ST_CRC_LO:    if (res_ok) n_state = ST_CRC_HI;
            ST_CRC_HI:    if (res_ok) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        n_cmd    = r_cmd;
        n_txh    = r_txh;
        n_hlen   = r_hlen;
        n_hidx   = r_hidx;
        n_isread = r_isread;
        n_ptr    = r_ptr;
        n_left   = r_left;
        n_fptr   = r_fptr;
        n_hi     = r_hi;
        n_tcrc   = r_tcrc;
        o_cmd_pop    = 1'b0;
        o_res_push   = 1'b0;
        o_res        = '0;
        o_frame_done = 1'b0;
        h_we     = 1'b0;
        h_waddr  = HW'(r_cmd.index);
        h_wdata  = r_cmd.value;
        h_re     = 1'b0;
        h_raddr  = HW'(r_cmd.index);
        in_we    = 1'b0;
        in_waddr = IW'(r_cmd.index);
        in_re    = 1'b0;
        in_raddr = IW'(r_ptr);
        f_re     = 1'b0;
        f_raddr  = r_fptr[FW-1:0];
        case (r_state)
            ST_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                end
            end
            ST_HOLD_WR: begin
                h_we = (17'(r_cmd.index) < HC17);
            end
            ST_INPUT_WR: begin
                in_we = (17'(r_cmd.index) < IC17);
            end
            ST_HOLD_RD: begin
                h_re = 1'b1;
            end
            ST_LOCAL_OUT: begin
                o_res_push       = res_ok;
                o_res.kind       = KIND_READ;
                o_res.last       = 1'b1;
                o_res.read_value = (17'(r_cmd.index) < HC17) ? r_hq : 16'd0;
            end
            ST_CHECK: begin
                n_tcrc   = CRC_INIT;
                n_hidx   = '0;
                n_hlen   = 3'd6;
                n_isread = 1'b0;
                n_txh[0] = i_cfg.slave_address;
                n_txh[1] = r_cmd.fc;
                n_txh[2] = r_cmd.start[15:8];
                n_txh[3] = r_cmd.start[7:0];
                n_txh[4] = r_cmd.qty[15:8];
                n_txh[5] = r_cmd.qty[7:0];
                n_ptr    = PW'(r_cmd.start);
                n_left   = 8'(r_cmd.qty);
                n_fptr   = (FW+1)'(7);
                if (fc_rd) begin
                    if (rd_ok) begin
                        n_txh[2] = {r_cmd.qty[6:0], 1'b0};
                        n_hlen   = 3'd3;
                        n_isread = 1'b1;
                    end else begin
                        n_txh[1] = r_cmd.fc | EXC_FLAG;
                        n_txh[2] = EXC_ILLEGAL_ADDR;
                        n_hlen   = 3'd3;
                    end
                end else if ((r_cmd.fc == FC_WR_SINGLE && !w6_ok) ||
                             (r_cmd.fc == FC_WR_MULTI && !w16_ok)) begin
                    n_txh[1] = r_cmd.fc | EXC_FLAG;
                    n_txh[2] = EXC_ILLEGAL_ADDR;
                    n_hlen   = 3'd3;
                end else if (r_cmd.fc != FC_WR_SINGLE && r_cmd.fc != FC_WR_MULTI) begin
                    n_txh[1] = r_cmd.fc | EXC_FLAG;
                    n_txh[2] = EXC_ILLEGAL_FUNC;
                    n_hlen   = 3'd3;
                end
            end
            ST_CRC_ERR: begin
                o_res_push   = res_ok;
                o_res.kind   = KIND_CRC_ERR;
                o_res.last   = 1'b1;
                o_frame_done = res_ok;
            end
            ST_W6: begin
                h_we    = 1'b1;
                h_waddr = HW'(r_cmd.start);
                h_wdata = r_cmd.qty;
            end
            ST_CLR1: begin
                h_we    = (17'(i_cfg.first_err_idx) < HC17);
                h_waddr = HW'(i_cfg.first_err_idx);
                h_wdata = '0;
            end
            ST_CLR2: begin
                h_we    = (17'(i_cfg.second_err_idx) < HC17);
                h_waddr = HW'(i_cfg.second_err_idx);
                h_wdata = '0;
            end
            ST_CLR3: begin
                h_we    = (17'(i_cfg.system_err_idx) < HC17);
                h_waddr = HW'(i_cfg.system_err_idx);
                h_wdata = '0;
            end
            ST_W16_RH: begin
                f_re   = 1'b1;
                n_fptr = r_fptr + 1'b1;
            end
            ST_W16_RL: begin
                n_hi   = r_frd;
                f_re   = 1'b1;
                n_fptr = r_fptr + 1'b1;
            end
            ST_W16_WR: begin
                h_we    = 1'b1;
                h_waddr = HW'(r_ptr);
                h_wdata = {r_hi, r_frd};
                n_ptr   = r_ptr + 1'b1;
                n_left  = r_left - 8'd1;
            end
            ST_HDR: begin
                o_res_push    = res_ok;
                o_res.kind    = KIND_TX;
                o_res.tx_byte = hdr_byte;
                if (res_ok) begin
                    n_tcrc = crc_byte(r_tcrc, hdr_byte);
                    n_hidx = r_hidx + 3'd1;
                end
            end
            ST_RD_ISSUE: begin
                h_re    = (r_cmd.fc == FC_RD_HOLD);
                h_raddr = HW'(r_ptr);
                in_re   = (r_cmd.fc != FC_RD_HOLD);
            end
            ST_RD_HI: begin
                o_res_push    = res_ok;
                o_res.kind    = KIND_TX;
                o_res.tx_byte = rd_word[15:8];
                if (res_ok) n_tcrc = crc_byte(r_tcrc, rd_word[15:8]);
            end
            ST_RD_LO: begin
                o_res_push    = res_ok;
                o_res.kind    = KIND_TX;
                o_res.tx_byte = rd_word[7:0];
                if (res_ok) begin
                    n_tcrc = crc_byte(r_tcrc, rd_word[7:0]);
                    n_ptr  = r_ptr + 1'b1;
                    n_left = r_left - 8'd1;
                end
            end
            ST_CRC_LO: begin
                o_res_push    = res_ok;
                o_res.kind    = KIND_TX;
                o_res.tx_byte = r_tcrc[7:0];
            end
            ST_CRC_HI: begin
                o_res_push    = res_ok;
                o_res.kind    = KIND_TX;
                o_res.tx_byte = r_tcrc[15:8];
                o_res.last    = 1'b1;
                o_frame_done  = res_ok;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // hold request and response context
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_txh    <= n_txh;
        r_hlen   <= n_hlen;
        r_hidx   <= n_hidx;
        r_isread <= n_isread;
        r_ptr    <= n_ptr;
        r_left   <= n_left;
        r_fptr   <= n_fptr;
        r_hi     <= n_hi;
        r_tcrc   <= n_tcrc;
    end

    // valid bits: an unwritten register reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hvld <= '0;
            r_ivld <= '0;
        end else begin
            if (h_we)  r_hvld[h_waddr]  <= 1'b1;
            if (in_we) r_ivld[in_waddr] <= 1'b1;
        end
    end

    // holding file
    always_ff @(posedge i_clk) begin
        if (h_we) m_hold[h_waddr] <= h_wdata;
        if (h_re) r_hq <= r_hvld[h_raddr] ? m_hold[h_raddr] : 16'd0;
    end

    // input file
    always_ff @(posedge i_clk) begin
        if (in_we) m_in[in_waddr] <= r_cmd.value;
        if (in_re) r_iq <= r_ivld[in_raddr] ? m_in[in_raddr] : 16'd0;
    end

    // frame buffer
    always_ff @(posedge i_clk) begin
        if (i_fbuf_wr.en) m_frame[i_fbuf_wr.addr[FW-1:0]] <= i_fbuf_wr.data;
        if (f_re) r_frd <= m_frame[f_raddr];
    end
endmodule

// File: hdl/modbus_rtu_register_slave.sv
// Modbus RTU register slave, top level.
// Depends on mrs_pkg, mrs_front, mrs_fifo and mrs_back.
//
// Input channel (i_push / o_full): one item per request - a received serial
// byte, a line error, a local holding or input write, or a local holding read.
// Result channel (o_empty / i_pop): response bytes (kind 0, o_last on the
// final CRC byte), local read data (kind 1) and CRC error events (kind 2).
// Configuration (i_cfg_valid / o_cfg_ready): always ready; registers 0..4 are
// slave address, reset-command index and the three error indexes.
// A local item or non-final byte is taken while o_full is low. The byte
// that completes an addressed frame blocks further input until its response
// is fully queued; the engine handles each register of a read or multiple
// write in turn, since it has one port each on the holding file and frame
// buffer. The first response byte passes the request queue and the engine's
// IDLE, CHECK and HDR states; a local read passes IDLE, HOLD_RD and LOCAL_OUT.
// When the receiver stalls, a four-entry result queue fills and the engine
// waits; the input side then fills a two-entry request queue and raises o_full.
// Reset clears control state and marks every register as zero; no sweep.
module modbus_rtu_register_slave #(
    parameter int HOLDING_COUNT      = 64,
    parameter int INPUT_COUNT        = 16,
    parameter int FRAME_BUFFER_BYTES = 64,
    parameter int MAX_READ_QTY       = 29
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_rx_byte,
    input  logic [5:0]  i_local_index,
    input  logic [15:0] i_local_value,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_tx_byte,
    output logic        o_last,
    output logic [15:0] o_read_value,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_addr,
    input  logic [7:0]  i_cfg_wdata
);
    import mrs_pkg::*;

    t_cfg     r_cfg;
    t_cmd     cmd_in, cmd_out;
    t_fbuf_wr fbuf_wr;
    t_result  res_in, res_out;
    logic     cmd_push, cmd_full, cmd_pop, cmd_empty;
    logic     res_push, res_full, frame_done;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slave_address  <= 8'd1;
            r_cfg.reset_cmd_idx  <= 6'd0;
            r_cfg.first_err_idx  <= 6'd1;
            r_cfg.second_err_idx <= 6'd2;
            r_cfg.system_err_idx <= 6'd3;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                CFG_SLAVE_ADDR: r_cfg.slave_address  <= i_cfg_wdata;
                CFG_RESET_CMD:  r_cfg.reset_cmd_idx  <= i_cfg_wdata[5:0];
                CFG_FIRST_ERR:  r_cfg.first_err_idx  <= i_cfg_wdata[5:0];
                CFG_SECOND_ERR: r_cfg.second_err_idx <= i_cfg_wdata[5:0];
                CFG_SYSTEM_ERR: r_cfg.system_err_idx <= i_cfg_wdata[5:0];
                default: begin
                end
            endcase
        end
    end

    mrs_front #(
        .FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_action     (i_action),
        .i_rx_byte    (i_rx_byte),
        .i_local_index(i_local_index),
        .i_local_value(i_local_value),
        .i_cfg        (r_cfg),
        .o_cmd_push   (cmd_push),
        .o_cmd        (cmd_in),
        .i_cmd_full   (cmd_full),
        .o_fbuf_wr    (fbuf_wr),
        .i_frame_done (frame_done)
    );

    mrs_fifo #(
        .WIDTH($bits(t_cmd)),
        .DEPTH(2)
    ) u_cmd_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (cmd_push),
        .i_data (cmd_in),
        .o_full (cmd_full),
        .i_pop  (cmd_pop),
        .o_data (cmd_out),
        .o_empty(cmd_empty)
    );

    mrs_back #(
        .HOLDING_COUNT     (HOLDING_COUNT),
        .INPUT_COUNT       (INPUT_COUNT),
        .FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES),
        .MAX_READ_QTY      (MAX_READ_QTY)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_cmd       (cmd_out),
        .i_fbuf_wr   (fbuf_wr),
        .o_res_push  (res_push),
        .o_res       (res_in),
        .i_res_full  (res_full),
        .o_frame_done(frame_done)
    );

    mrs_fifo #(
        .WIDTH($bits(t_result)),
        .DEPTH(4)
    ) u_res_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (res_push),
        .i_data (res_in),
        .o_full (res_full),
        .i_pop  (i_pop),
        .o_data (res_out),
        .o_empty(o_empty)
    );

    assign o_kind       = res_out.kind;
    assign o_tx_byte    = res_out.tx_byte;
    assign o_last       = res_out.last;
    assign o_read_value = res_out.read_value;
endmodule

// File: hdl/mrs_checker.sv
// Port-level checks on the Modbus RTU register slave, bound to the top level.
// Depends on mrs_pkg for result kinds.
module mrs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_push,
    input logic        o_full,
    input logic [2:0]  i_action,
    input logic [7:0]  i_rx_byte,
    input logic [5:0]  i_local_index,
    input logic [15:0] i_local_value,
    input logic        o_empty,
    input logic        i_pop,
    input logic [1:0]  o_kind,
    input logic [7:0]  o_tx_byte,
    input logic        o_last,
    input logic [15:0] o_read_value,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [2:0]  i_cfg_addr,
    input logic [7:0]  i_cfg_wdata
);
    import mrs_pkg::*;

    // reset leaves no result waiting
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> o_empty)
        else $error("result waiting after reset");

    // local reads and error events are single, final items
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && (o_kind == KIND_READ || o_kind == KIND_CRC_ERR)) |-> o_last)
        else $error("single result without last");

    // unused fields stay zero
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> ((o_kind == KIND_TX && o_read_value == 16'd0) ||
                      (o_kind == KIND_READ && o_tx_byte == 8'd0) ||
                      (o_kind == KIND_CRC_ERR && o_tx_byte == 8'd0 &&
                       o_read_value == 16'd0)))
        else $error("bad result kind or stray field");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_tx_byte) && $stable(o_kind)))
        else $error("stalled result changed");
endmodule

bind modbus_rtu_register_slave mrs_checker u_mrs_checker (.*);
